// ===== rtl/hinv_pkg.sv =====
// ----------------------------------------------------------------------------
// hinv_pkg
// Shared types and constants of the homography inverse mapping block.
// ----------------------------------------------------------------------------
package hinv_pkg;

	// Coordinate and fixed-point widths.
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 24;
	localparam int COEF_BITS  = 32;
	localparam int SIZE_BITS  = COORD_BITS + 1;
	// Product of a signed coefficient with an unsigned coordinate.
	localparam int PROD_BITS  = COEF_BITS + COORD_BITS + 1;
	// Sum of two products and an aligned offset.
	localparam int SUM_BITS   = PROD_BITS + 2;
	// Shifted divisor width used by the restoring divider.
	localparam int DIV_BITS   = SUM_BITS + COORD_BITS;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SCALE_XX    = 3'd0,
		REG_SCALE_XY    = 3'd1,
		REG_PERSP_X     = 3'd2,
		REG_SCALE_YX    = 3'd3,
		REG_SCALE_YY    = 3'd4,
		REG_PERSP_Y     = 3'd5,
		REG_ORIGIN_XY   = 3'd6,
		REG_SOURCE_SIZE = 3'd7
	} reg_idx_t;

	// Input transaction: one destination pixel.
	typedef struct packed {
		logic [COORD_BITS-1:0] dst_x;
		logic [COORD_BITS-1:0] dst_y;
	} in_t;

	// Output transaction: source pixel and range flag.
	typedef struct packed {
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic                  in_range;
	} out_t;

endpackage

// ===== rtl/homography_inverse_map.sv =====
// ----------------------------------------------------------------------------
// homography_inverse_map
// Maps a destination pixel through a fixed-point 3x3 projective transform.
// ----------------------------------------------------------------------------
// The block accepts one destination pixel per clock and returns the source
// pixel, truncated toward zero, with a flag that says whether it lies inside
// the source image. The pipeline has one stage of multipliers, one of sums,
// one of sign and range preparation, one restoring divider stage per
// quotient bit, and the output register. The throughput is one transaction
// per cycle; the whole pipeline holds while a result waits at a stalled
// output. Coefficients are Q7.24 and must only be written while no
// transaction is in flight.
module homography_inverse_map (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hinv_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [hinv_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  hinv_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output hinv_pkg::out_t                       out_data
);

	localparam int CB = hinv_pkg::COORD_BITS;
	localparam int PB = hinv_pkg::PROD_BITS;
	localparam int SB = hinv_pkg::SUM_BITS;
	localparam int DB = hinv_pkg::DIV_BITS;
	localparam int FB = hinv_pkg::FRAC_BITS;
	localparam int KB = hinv_pkg::COEF_BITS;
	localparam int ZB = hinv_pkg::SIZE_BITS;

	// Configuration registers.
	logic signed [KB-1:0] scale_xx_q, scale_xy_q, persp_x_q;
	logic signed [KB-1:0] scale_yx_q, scale_yy_q, persp_y_q;
	logic [2*CB-1:0]      origin_xy_q;
	logic [2*ZB-1:0]      source_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_xx_q    <= KB'(1) << FB;
			scale_xy_q    <= '0;
			persp_x_q     <= '0;
			scale_yx_q    <= '0;
			scale_yy_q    <= KB'(1) << FB;
			persp_y_q     <= '0;
			origin_xy_q   <= '0;
			source_size_q <= '0;
		end else if (cfg_we) begin
			unique case (hinv_pkg::reg_idx_t'(cfg_index))
				hinv_pkg::REG_SCALE_XX:    scale_xx_q    <= cfg_data[KB-1:0];
				hinv_pkg::REG_SCALE_XY:    scale_xy_q    <= cfg_data[KB-1:0];
				hinv_pkg::REG_PERSP_X:     persp_x_q     <= cfg_data[KB-1:0];
				hinv_pkg::REG_SCALE_YX:    scale_yx_q    <= cfg_data[KB-1:0];
				hinv_pkg::REG_SCALE_YY:    scale_yy_q    <= cfg_data[KB-1:0];
				hinv_pkg::REG_PERSP_Y:     persp_y_q     <= cfg_data[KB-1:0];
				hinv_pkg::REG_ORIGIN_XY:   origin_xy_q   <= cfg_data[2*CB-1:0];
				hinv_pkg::REG_SOURCE_SIZE: source_size_q <= cfg_data[2*ZB-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a result waits at a stalled output.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: six products.
	logic                 vld_s1;
	logic signed [PB-1:0] pxx_s1, pxy_s1, ppx_s1, pyx_s1, pyy_s1, ppy_s1;
	logic signed [CB:0]   sx, sy;
	assign sx = $signed({1'b0, in_data.dst_x});
	assign sy = $signed({1'b0, in_data.dst_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s1 <= PB'(scale_xx_q * sx);
			pxy_s1 <= PB'(scale_xy_q * sx);
			ppx_s1 <= PB'(persp_x_q  * sx);
			pyx_s1 <= PB'(scale_yx_q * sy);
			pyy_s1 <= PB'(scale_yy_q * sy);
			ppy_s1 <= PB'(persp_y_q  * sy);
		end
	end

	// Stage 2: numerators and denominator with the aligned offsets.
	logic                 vld_s2;
	logic signed [SB-1:0] nx_s2, ny_s2, dn_s2;
	logic signed [SB-1:0] ox, oy, one;
	assign ox  = $signed(SB'(origin_xy_q[CB-1:0]) << FB);
	assign oy  = $signed(SB'(origin_xy_q[2*CB-1:CB]) << FB);
	assign one = $signed(SB'(1) << FB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s2 <= SB'(pxx_s1) + SB'(pyx_s1) + ox;
			ny_s2 <= SB'(pxy_s1) + SB'(pyy_s1) + oy;
			dn_s2 <= SB'(ppx_s1) + SB'(ppy_s1) + one;
		end
	end

	// Stage 3: magnitudes, sign differences and overflow of the quotient.
	logic          vld_s3;
	logic [SB-1:0] ax_s3, ay_s3, bd_s3;
	logic          bad_s3, negx_s3, negy_s3;
	logic [SB-1:0] ax, ay, bd;
	logic          ovx, ovy;
	assign ax  = nx_s2[SB-1] ? SB'(-nx_s2) : SB'(nx_s2);
	assign ay  = ny_s2[SB-1] ? SB'(-ny_s2) : SB'(ny_s2);
	assign bd  = dn_s2[SB-1] ? SB'(-dn_s2) : SB'(dn_s2);
	assign ovx = DB'(ax) >= (DB'(bd) << CB);
	assign ovy = DB'(ay) >= (DB'(bd) << CB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s3   <= ax;
			ay_s3   <= ay;
			bd_s3   <= bd;
			bad_s3  <= (dn_s2 == '0) || ovx || ovy;
			negx_s3 <= nx_s2[SB-1] ^ dn_s2[SB-1];
			negy_s3 <= ny_s2[SB-1] ^ dn_s2[SB-1];
		end
	end

	// Restoring divider: one quotient bit of each coordinate per stage.
	logic          dv_vld  [0:CB];
	logic [SB-1:0] dv_rx   [0:CB];
	logic [SB-1:0] dv_ry   [0:CB];
	logic [SB-1:0] dv_b    [0:CB];
	logic [CB-1:0] dv_qx   [0:CB];
	logic [CB-1:0] dv_qy   [0:CB];
	logic          dv_bad  [0:CB];
	logic          dv_negx [0:CB];
	logic          dv_negy [0:CB];

	assign dv_vld[0]  = vld_s3;
	assign dv_rx[0]   = ax_s3;
	assign dv_ry[0]   = ay_s3;
	assign dv_b[0]    = bd_s3;
	assign dv_qx[0]   = '0;
	assign dv_qy[0]   = '0;
	assign dv_bad[0]  = bad_s3;
	assign dv_negx[0] = negx_s3;
	assign dv_negy[0] = negy_s3;

	for (genvar k = 0; k < CB; k++) begin : g_div
		localparam int BIT = CB - 1 - k;
		logic [DB-1:0] dsh;
		logic          gex, gey;
		assign dsh = DB'(dv_b[k]) << BIT;
		assign gex = DB'(dv_rx[k]) >= dsh;
		assign gey = DB'(dv_ry[k]) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld[k+1] <= dv_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rx[k+1]   <= gex ? SB'(DB'(dv_rx[k]) - dsh) : dv_rx[k];
				dv_ry[k+1]   <= gey ? SB'(DB'(dv_ry[k]) - dsh) : dv_ry[k];
				dv_qx[k+1]   <= dv_qx[k] | (CB'(gex) << BIT);
				dv_qy[k+1]   <= dv_qy[k] | (CB'(gey) << BIT);
				dv_b[k+1]    <= dv_b[k];
				dv_bad[k+1]  <= dv_bad[k];
				dv_negx[k+1] <= dv_negx[k];
				dv_negy[k+1] <= dv_negy[k];
			end
		end
	end

	// Output register: sign and source range check.
	logic [ZB-1:0] width, height;
	logic          ok;
	assign width  = source_size_q[ZB-1:0];
	assign height = source_size_q[2*ZB-1:ZB];
	assign ok = !dv_bad[CB]
		&& !(dv_negx[CB] && (dv_qx[CB] != '0))
		&& !(dv_negy[CB] && (dv_qy[CB] != '0))
		&& (ZB'(dv_qx[CB]) < width)
		&& (ZB'(dv_qy[CB]) < height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_vld[CB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.src_x    <= ok ? dv_qx[CB] : '0;
			out_data.src_y    <= ok ? dv_qy[CB] : '0;
			out_data.in_range <= ok;
		end
	end

endmodule
